### rtl/hbs_pkg.sv
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types and constants for the heightmap bilinear sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int DATA_W    = 32;
    localparam int MID_W     = 48;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 3'd4;

    // Item operations
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Interpolated row heights are held to +-(2^47 - 1)
    localparam longint MID_LIM = (64'sd1 <<< (MID_W - 1)) - 64'sd1;

    // Control that travels with each beat down the pipeline
    typedef struct packed {
        logic valid;
        logic query;
    } hbs_ctl_t;

endpackage

### rtl/hbs_ram.sv
// ----------------------------------------------------------------------------
// hbs_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/hbs_cell_map.sv
// ----------------------------------------------------------------------------
// hbs_cell_map
// World-to-grid mapping: scale by reciprocal spacing, then pick the cell
// and the unclamped fraction. Two register stages.
// ----------------------------------------------------------------------------
module hbs_cell_map #(
    parameter int FRAC_BITS = 16,
    parameter int MAX_COLS  = 256,
    parameter int MAX_ROWS  = 256,
    parameter int SIDE_W    = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  hbs_pkg::hbs_ctl_t                    ctl_in,
    input  logic signed [32:0]                   dx,
    input  logic signed [32:0]                   dz,
    input  logic [SIDE_W-1:0]                    side_in,
    input  logic [30:0]                          inv_spacing,
    input  logic [$clog2(MAX_COLS+1)-1:0]        cols_use,
    input  logic [$clog2(MAX_ROWS+1)-1:0]        rows_use,
    output hbs_pkg::hbs_ctl_t                    ctl_out,
    output logic [$clog2(MAX_COLS)-1:0]          col,
    output logic [$clog2(MAX_ROWS)-1:0]          row,
    output logic signed [63-FRAC_BITS:0]         t,
    output logic signed [63-FRAC_BITS:0]         u,
    output logic [SIDE_W-1:0]                    side_out
);
    import hbs_pkg::*;

    localparam int FW = 64 - FRAC_BITS;
    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);

    logic signed [64:0]   prod_x;
    logic signed [64:0]   prod_z;
    hbs_ctl_t             ctl1_reg;
    logic signed [FW-1:0] fc_reg;
    logic signed [FW-1:0] fr_reg;
    logic [SIDE_W-1:0]    side1_reg;

    logic [63:0]          cidx;
    logic [63:0]          ridx;
    logic [63:0]          clim;
    logic [63:0]          rlim;
    logic [CW-1:0]        col_next;
    logic [RW-1:0]        row_next;
    logic signed [FW-1:0] t_next;
    logic signed [FW-1:0] u_next;

    hbs_ctl_t             ctl2_reg;
    logic [CW-1:0]        col_reg;
    logic [RW-1:0]        row_reg;
    logic signed [FW-1:0] t_reg;
    logic signed [FW-1:0] u_reg;
    logic [SIDE_W-1:0]    side2_reg;

    // stage 1: scale offsets into grid units (floor by arithmetic shift)
    assign prod_x = dx * $signed({1'b0, inv_spacing});
    assign prod_z = dz * $signed({1'b0, inv_spacing});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        fc_reg    <= prod_x[63:FRAC_BITS];
        fr_reg    <= prod_z[63:FRAC_BITS];
        side1_reg <= side_in;
    end

    // stage 2: cell index, clamped to [0, size-2]; fraction left unclamped
    always_comb
    begin
        cidx = 64'(fc_reg[FW-1:FRAC_BITS]);
        ridx = 64'(fr_reg[FW-1:FRAC_BITS]);
        clim = 64'(cols_use) - 64'd2;
        rlim = 64'(rows_use) - 64'd2;

        if (fc_reg[FW-1])
        begin
            col_next = '0;
        end
        else if (cidx > clim)
        begin
            col_next = CW'(clim);
        end
        else
        begin
            col_next = CW'(cidx);
        end

        if (fr_reg[FW-1])
        begin
            row_next = '0;
        end
        else if (ridx > rlim)
        begin
            row_next = RW'(rlim);
        end
        else
        begin
            row_next = RW'(ridx);
        end

        t_next = fc_reg - $signed({{(FW-CW-FRAC_BITS){1'b0}}, col_next, {FRAC_BITS{1'b0}}});
        u_next = fr_reg - $signed({{(FW-RW-FRAC_BITS){1'b0}}, row_next, {FRAC_BITS{1'b0}}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
        end
        else
        begin
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg   <= col_next;
        row_reg   <= row_next;
        t_reg     <= t_next;
        u_reg     <= u_next;
        side2_reg <= side1_reg;
    end

    assign ctl_out  = ctl2_reg;
    assign col      = col_reg;
    assign row      = row_reg;
    assign t        = t_reg;
    assign u        = u_reg;
    assign side_out = side2_reg;

endmodule

### rtl/hbs_interp.sv
// ----------------------------------------------------------------------------
// hbs_interp
// Bilinear blend of four corner heights: split multiplies, row lerps,
// column lerp with offset, saturation and the surface compare.
// ----------------------------------------------------------------------------
module hbs_interp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  hbs_pkg::hbs_ctl_t            ctl_in,
    input  logic signed [63-FRAC_BITS:0] t,
    input  logic signed [63-FRAC_BITS:0] u,
    input  logic signed [31:0]           v00,
    input  logic signed [31:0]           v01,
    input  logic signed [31:0]           v10,
    input  logic signed [31:0]           v11,
    input  logic signed [31:0]           py,
    input  logic signed [31:0]           off,
    output logic                         done,
    output logic signed [31:0]           surface_height,
    output logic                         below_surface,
    output logic                         saturated
);
    import hbs_pkg::*;

    localparam int FW = 64 - FRAC_BITS;
    localparam int TL = FW / 2;
    localparam int TH = FW - TL;
    localparam int PW = 33 + FW;
    localparam int SW = PW - FRAC_BITS + 1;
    localparam int DW = MID_W + 1;
    localparam int DL = 24;
    localparam int DH = DW - DL;
    localparam int QW = DW + FW + 1;
    localparam int HW = QW - FRAC_BITS + 2;

    localparam logic signed [SW-1:0] Y_HI = SW'(MID_LIM);
    localparam logic signed [SW-1:0] Y_LO = -Y_HI;
    localparam logic signed [HW-1:0] H_HI = HW'(64'sd2147483647);
    localparam logic signed [HW-1:0] H_LO = HW'(-64'sd2147483648);

    // stage A: corner differences times split t
    logic signed [32:0]     d0;
    logic signed [32:0]     d1;
    logic signed [TL:0]     tl_s;
    logic signed [TH-1:0]   th_s;
    hbs_ctl_t               ctla_reg;
    logic signed [33+TL:0]  p0l_reg;
    logic signed [32+TH:0]  p0h_reg;
    logic signed [33+TL:0]  p1l_reg;
    logic signed [32+TH:0]  p1h_reg;
    logic signed [31:0]     a0_reg;
    logic signed [31:0]     a1_reg;
    logic signed [FW-1:0]   ua_reg;
    logic signed [31:0]     pya_reg;
    logic signed [31:0]     offa_reg;

    assign d0   = 33'(v01) - 33'(v00);
    assign d1   = 33'(v11) - 33'(v10);
    assign tl_s = $signed({1'b0, t[TL-1:0]});
    assign th_s = $signed(t[FW-1:TL]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctla_reg <= '0;
        end
        else
        begin
            ctla_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        p0l_reg  <= d0 * tl_s;
        p0h_reg  <= d0 * th_s;
        p1l_reg  <= d1 * tl_s;
        p1h_reg  <= d1 * th_s;
        a0_reg   <= v00;
        a1_reg   <= v10;
        ua_reg   <= u;
        pya_reg  <= py;
        offa_reg <= off;
    end

    // stage B: row lerps, clipped to the mid range
    logic signed [PW-1:0]    prod0;
    logic signed [PW-1:0]    prod1;
    logic signed [SW-1:0]    s0;
    logic signed [SW-1:0]    s1;
    logic signed [MID_W-1:0] y0_next;
    logic signed [MID_W-1:0] y1_next;
    logic                    sat_b_next;
    hbs_ctl_t                ctlb_reg;
    logic signed [MID_W-1:0] y0b_reg;
    logic signed [MID_W-1:0] y1b_reg;
    logic                    satb_reg;
    logic signed [FW-1:0]    ub_reg;
    logic signed [31:0]      pyb_reg;
    logic signed [31:0]      offb_reg;

    always_comb
    begin
        prod0 = (PW'(p0h_reg) <<< TL) + PW'(p0l_reg);
        prod1 = (PW'(p1h_reg) <<< TL) + PW'(p1l_reg);
        s0 = SW'($signed(prod0[PW-1:FRAC_BITS])) + SW'(a0_reg);
        s1 = SW'($signed(prod1[PW-1:FRAC_BITS])) + SW'(a1_reg);
        sat_b_next = 1'b0;
        if (s0 > Y_HI)
        begin
            y0_next = MID_W'(Y_HI);
            sat_b_next = 1'b1;
        end
        else if (s0 < Y_LO)
        begin
            y0_next = MID_W'(Y_LO);
            sat_b_next = 1'b1;
        end
        else
        begin
            y0_next = MID_W'(s0);
        end
        if (s1 > Y_HI)
        begin
            y1_next = MID_W'(Y_HI);
            sat_b_next = 1'b1;
        end
        else if (s1 < Y_LO)
        begin
            y1_next = MID_W'(Y_LO);
            sat_b_next = 1'b1;
        end
        else
        begin
            y1_next = MID_W'(s1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctlb_reg <= '0;
        end
        else
        begin
            ctlb_reg <= ctla_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        y0b_reg  <= y0_next;
        y1b_reg  <= y1_next;
        satb_reg <= sat_b_next;
        ub_reg   <= ua_reg;
        pyb_reg  <= pya_reg;
        offb_reg <= offa_reg;
    end

    // stage C: (y1 - y0) times u as four partial products
    logic signed [DW-1:0]  dy;
    logic signed [DL:0]    dyl_s;
    logic signed [DH-1:0]  dyh_s;
    logic signed [TL:0]    ul_s;
    logic signed [TH-1:0]  uh_s;
    hbs_ctl_t              ctlc_reg;
    logic signed [DL+TL+1:0] ll_reg;
    logic signed [DL+TH:0]   lh_reg;
    logic signed [DH+TL:0]   hl_reg;
    logic signed [DH+TH-1:0] hh_reg;
    logic signed [MID_W-1:0] y0c_reg;
    logic                    satc_reg;
    logic signed [31:0]      pyc_reg;
    logic signed [31:0]      offc_reg;

    assign dy    = DW'(y1b_reg) - DW'(y0b_reg);
    assign dyl_s = $signed({1'b0, dy[DL-1:0]});
    assign dyh_s = $signed(dy[DW-1:DL]);
    assign ul_s  = $signed({1'b0, ub_reg[TL-1:0]});
    assign uh_s  = $signed(ub_reg[FW-1:TL]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctlc_reg <= '0;
        end
        else
        begin
            ctlc_reg <= ctlb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ll_reg   <= dyl_s * ul_s;
        lh_reg   <= dyl_s * uh_s;
        hl_reg   <= dyh_s * ul_s;
        hh_reg   <= dyh_s * uh_s;
        y0c_reg  <= y0b_reg;
        satc_reg <= satb_reg;
        pyc_reg  <= pyb_reg;
        offc_reg <= offb_reg;
    end

    // stage D: column lerp plus offset, clipped to 32 bits
    logic signed [QW-1:0] prod2;
    logic signed [HW-1:0] hsum;
    logic signed [31:0]   h_next;
    logic                 hclip;
    hbs_ctl_t             ctld_reg;
    logic signed [31:0]   hd_reg;
    logic                 satd_reg;
    logic signed [31:0]   pyd_reg;

    always_comb
    begin
        prod2 = (QW'(hh_reg) <<< (DL + TL)) + (QW'(lh_reg) <<< TL)
              + (QW'(hl_reg) <<< DL) + QW'(ll_reg);
        hsum  = HW'($signed(prod2[QW-1:FRAC_BITS])) + HW'(y0c_reg) + HW'(offc_reg);
        hclip = 1'b1;
        if (hsum > H_HI)
        begin
            h_next = 32'(H_HI);
        end
        else if (hsum < H_LO)
        begin
            h_next = 32'(H_LO);
        end
        else
        begin
            h_next = 32'(hsum);
            hclip  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctld_reg <= '0;
        end
        else
        begin
            ctld_reg <= ctlc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hd_reg   <= h_next;
        satd_reg <= satc_reg | hclip;
        pyd_reg  <= pyc_reg;
    end

    // stage E: surface compare, result registers
    logic               done_reg;
    logic signed [31:0] height_reg;
    logic               below_reg;
    logic               sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctld_reg.valid & (ctld_reg.query == FUNC_QUERY);
        end
    end

    always_ff @(posedge clk)
    begin
        height_reg <= hd_reg;
        below_reg  <= (pyd_reg <= hd_reg);
        sat_reg    <= satd_reg;
    end

    assign done           = done_reg;
    assign surface_height = height_reg;
    assign below_surface  = below_reg;
    assign saturated      = sat_reg;

endmodule

### rtl/heightmap_bilinear_sampler_top.sv
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_top
// Heightmap store with a pipelined bilinear height query.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken at each rising edge with start high;
//   busy stays low, so a new beat may follow every cycle. func selects a
//   vertex write (vertex_index, vertex_height) or a query (pos_x, pos_z,
//   pos_y, height_offset).
//   A write produces no result. A query produces one result beat: done is
//   high for one cycle with surface_height, below_surface and saturated,
//   after the capture, grid-mapping, grid-access and interpolation stages.
//   Throughput is one beat per cycle; the four corner reads are served by four
//   grid copies, each with its own read port, written together.
//   Writes travel down the same pipeline as queries and update the grid at
//   the read stage, so every query sees exactly the writes issued before it.
//   Results cannot be held off; the receiver must take each done beat.
//   Configuration (cfg_write/cfg_index/cfg_data) must be written only while
//   no beat is in flight; the block does not enforce this. Indexes outside
//   the register list are ignored. Reset clears the pipeline valid bits and
//   loads default configuration; grid contents are undefined until written.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler_top #(
    parameter int MAX_COLS  = 256,
    parameter int MAX_ROWS  = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_write,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hbs_pkg::DATA_W-1:0]     cfg_data,
    // command
    input  logic                           start,
    output logic                           busy,
    input  logic                           func,
    input  logic [15:0]                    vertex_index,
    input  logic signed [31:0]             vertex_height,
    input  logic signed [31:0]             pos_x,
    input  logic signed [31:0]             pos_z,
    input  logic signed [31:0]             pos_y,
    input  logic signed [31:0]             height_offset,
    // result
    output logic                           done,
    output logic signed [31:0]             surface_height,
    output logic                           below_surface,
    output logic                           saturated
);
    import hbs_pkg::*;

    localparam int FW      = 64 - FRAC_BITS;
    localparam int CW      = $clog2(MAX_COLS);
    localparam int RW      = $clog2(MAX_ROWS);
    localparam int NCW     = $clog2(MAX_COLS + 1);
    localparam int NRW     = $clog2(MAX_ROWS + 1);
    localparam int DEPTH   = MAX_COLS * MAX_ROWS;
    localparam int AW      = $clog2(DEPTH);
    localparam int SIDE_W  = 16 + 32 * 3;
    localparam int LATENCY = 9;

    // ---------------- configuration registers ----------------
    logic signed [31:0] origin_x_reg;
    logic signed [31:0] origin_z_reg;
    logic [30:0]        inv_spacing_reg;
    logic [8:0]         cols_in_use_reg;
    logic [8:0]         rows_in_use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_z_reg    <= '0;
            inv_spacing_reg <= 31'(64'd1 << FRAC_BITS);
            cols_in_use_reg <= 9'd256;
            rows_in_use_reg <= 9'd256;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ORIGIN_X:    origin_x_reg    <= cfg_data;
                REG_ORIGIN_Z:    origin_z_reg    <= cfg_data;
                REG_INV_SPACING: inv_spacing_reg <= cfg_data[30:0];
                REG_COLS_IN_USE: cols_in_use_reg <= cfg_data[8:0];
                REG_ROWS_IN_USE: rows_in_use_reg <= cfg_data[8:0];
                default:         ;
            endcase
        end
    end

    // grid size in use, held to [2, MAX]
    logic [NCW-1:0] cols_use;
    logic [NRW-1:0] rows_use;

    always_comb
    begin
        if (cols_in_use_reg < 9'd2)
        begin
            cols_use = NCW'(2);
        end
        else if (32'(cols_in_use_reg) > 32'(MAX_COLS))
        begin
            cols_use = NCW'(MAX_COLS);
        end
        else
        begin
            cols_use = NCW'(cols_in_use_reg);
        end

        if (rows_in_use_reg < 9'd2)
        begin
            rows_use = NRW'(2);
        end
        else if (32'(rows_in_use_reg) > 32'(MAX_ROWS))
        begin
            rows_use = NRW'(MAX_ROWS);
        end
        else
        begin
            rows_use = NRW'(rows_in_use_reg);
        end
    end

    // ---------------- stage 0: capture beat, offsets from origin ----------------
    assign busy = 1'b0;

    hbs_ctl_t           ctl0_reg;
    logic signed [32:0] dx_reg;
    logic signed [32:0] dz_reg;
    logic [SIDE_W-1:0]  side0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
        end
        else
        begin
            ctl0_reg.valid <= start & ~busy;
            ctl0_reg.query <= func;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg    <= 33'(pos_x) - 33'(origin_x_reg);
        dz_reg    <= 33'(pos_z) - 33'(origin_z_reg);
        side0_reg <= {vertex_index, vertex_height, pos_y, height_offset};
    end

    // ---------------- stages 1-2: grid mapping ----------------
    hbs_ctl_t             ctl2;
    logic [CW-1:0]        col2;
    logic [RW-1:0]        row2;
    logic signed [FW-1:0] t2;
    logic signed [FW-1:0] u2;
    logic [SIDE_W-1:0]    side2;

    hbs_cell_map #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .SIDE_W    (SIDE_W)
    ) u_cell_map (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl_in      (ctl0_reg),
        .dx          (dx_reg),
        .dz          (dz_reg),
        .side_in     (side0_reg),
        .inv_spacing (inv_spacing_reg),
        .cols_use    (cols_use),
        .rows_use    (rows_use),
        .ctl_out     (ctl2),
        .col         (col2),
        .row         (row2),
        .t           (t2),
        .u           (u2),
        .side_out    (side2)
    );

    // ---------------- stage 3: grid access ----------------
    logic [15:0]        wr_index;
    logic signed [31:0] wr_height;
    logic signed [31:0] py2;
    logic signed [31:0] off2;
    logic [AW:0]        base;
    logic [AW:0]        a00;
    logic [AW:0]        a01;
    logic [AW:0]        a10;
    logic [AW:0]        a11;
    logic               wr_en;

    assign {wr_index, wr_height, py2, off2} = side2;

    // corners: base, base+1, base+cols, base+cols+1
    always_comb
    begin
        base = (AW+1)'(row2) * (AW+1)'(cols_use) + (AW+1)'(col2);
        a00  = base;
        a01  = base + (AW+1)'(1);
        a10  = base + (AW+1)'(cols_use);
        a11  = a10 + (AW+1)'(1);
    end

    // out-of-grid writes are dropped
    assign wr_en = ctl2.valid & (ctl2.query == FUNC_WRITE)
                 & (32'(wr_index) < 32'(DEPTH));

    logic [31:0] v00;
    logic [31:0] v01;
    logic [31:0] v10;
    logic [31:0] v11;

    hbs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram00 (
        .clk (clk), .we (wr_en), .waddr (AW'(wr_index)), .wdata (wr_height),
        .raddr (AW'(a00)), .rdata (v00)
    );
    hbs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram01 (
        .clk (clk), .we (wr_en), .waddr (AW'(wr_index)), .wdata (wr_height),
        .raddr (AW'(a01)), .rdata (v01)
    );
    hbs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram10 (
        .clk (clk), .we (wr_en), .waddr (AW'(wr_index)), .wdata (wr_height),
        .raddr (AW'(a10)), .rdata (v10)
    );
    hbs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram11 (
        .clk (clk), .we (wr_en), .waddr (AW'(wr_index)), .wdata (wr_height),
        .raddr (AW'(a11)), .rdata (v11)
    );

    hbs_ctl_t             ctl3_reg;
    logic signed [FW-1:0] t3_reg;
    logic signed [FW-1:0] u3_reg;
    logic signed [31:0]   py3_reg;
    logic signed [31:0]   off3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl3_reg <= '0;
        end
        else
        begin
            ctl3_reg <= ctl2;
        end
    end

    always_ff @(posedge clk)
    begin
        t3_reg   <= t2;
        u3_reg   <= u2;
        py3_reg  <= py2;
        off3_reg <= off2;
    end

    // ---------------- stages A-E: interpolation ----------------
    hbs_interp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_interp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl_in         (ctl3_reg),
        .t              (t3_reg),
        .u              (u3_reg),
        .v00            ($signed(v00)),
        .v01            ($signed(v01)),
        .v10            ($signed(v10)),
        .v11            ($signed(v11)),
        .py             (py3_reg),
        .off            (off3_reg),
        .done           (done),
        .surface_height (surface_height),
        .below_surface  (below_surface),
        .saturated      (saturated)
    );

    // ---------------- assertions ----------------
    a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == FUNC_QUERY) |-> ##LATENCY done)
        else $error("query beat did not produce a result");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == FUNC_WRITE) |-> ##LATENCY !done)
        else $error("write beat produced a result");

    a_corner_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl2.valid && ctl2.query == FUNC_QUERY) |-> (32'(a11) < 32'(DEPTH)))
        else $error("corner address beyond grid");

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the heightmap bilinear sampler.
// Writes the four corners of each query cell on demand, then runs directed
// and random beats through several register settings. A scoreboard class
// predicts every query result.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import hbs_pkg::*;

    localparam int GRID_DEPTH = 65536;
    localparam int LAT_WAIT   = 14;     // pipeline is nine deep, plus margin

    typedef struct {
        logic [31:0] surface_height;
        logic        below_surface;
        logic        saturated;
    } height_result_t;

    // ------------------------------------------------------------------
    // Scoreboard: own copy of the grid and registers, queue of expected
    // query results.
    // ------------------------------------------------------------------
    class height_scoreboard;
        int             grid [GRID_DEPTH];
        bit             written [GRID_DEPTH];
        longint         org_x;
        longint         org_z;
        longint         inv_sp;
        int             cols_cfg;
        int             rows_cfg;
        height_result_t pending [$];
        int             errors;

        function void reset_regs();
            org_x    = 0;
            org_z    = 0;
            inv_sp   = 65536;
            cols_cfg = 256;
            rows_cfg = 256;
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_ORIGIN_X:    org_x    = longint'(signed'(data));
                REG_ORIGIN_Z:    org_z    = longint'(signed'(data));
                REG_INV_SPACING: inv_sp   = longint'(data[30:0]);
                REG_COLS_IN_USE: cols_cfg = int'(data[8:0]);
                REG_ROWS_IN_USE: rows_cfg = int'(data[8:0]);
                default: ;
            endcase
        endfunction

        // floor(a*b / 2^16), magnitude clipped to lim
        function longint scale_mul(longint a, longint b, longint lim, inout bit sat);
            bit           neg;
            logic [63:0]  ua;
            logic [63:0]  ub;
            logic [127:0] prod;
            logic [127:0] q;
            neg  = (a < 0) != (b < 0);
            ua   = (a < 0) ? -a : a;
            ub   = (b < 0) ? -b : b;
            prod = {64'd0, ua} * {64'd0, ub};
            q    = prod >> 16;
            if (neg && prod[15:0] != 0)
                q = q + 1;
            if (q > {64'd0, lim}) begin
                sat = 1'b1;
                q   = {64'd0, lim};
            end
            return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
        endfunction

        function int clamp_size(int v);
            if (v < 2)
                return 2;
            return (v > 256) ? 256 : v;
        endfunction

        function longint cell_of(longint f, int size);
            longint c;
            if (f < 0)
                return 0;
            c = f >>> 16;
            return (c > size - 2) ? size - 2 : c;
        endfunction

        function longint lerp(longint a, longint b, longint t, inout bit sat);
            longint v;
            longint mid_lim;
            mid_lim = (longint'(1) <<< 47) - 1;
            v = a + scale_mul(b - a, t, longint'(1) <<< 62, sat);
            if (v > mid_lim) begin sat = 1'b1; v = mid_lim; end
            if (v < -mid_lim) begin sat = 1'b1; v = -mid_lim; end
            return v;
        endfunction

        // Grid index of the lower corner of the cell a query lands on
        function int query_base(logic [31:0] px, logic [31:0] pz, output int cols);
            bit     dummy;
            int     rows;
            longint fc, fr, col, row;
            dummy = 1'b0;
            cols  = clamp_size(cols_cfg);
            rows  = clamp_size(rows_cfg);
            fc    = scale_mul(longint'(signed'(px)) - org_x, inv_sp, longint'(1) <<< 62, dummy);
            fr    = scale_mul(longint'(signed'(pz)) - org_z, inv_sp, longint'(1) <<< 62, dummy);
            col   = cell_of(fc, cols);
            row   = cell_of(fr, rows);
            return int'(row) * cols + int'(col);
        endfunction

        // Called for every accepted command beat
        function void note_beat(logic fn, logic [15:0] vidx, logic [31:0] vh,
                                logic [31:0] px, logic [31:0] pz,
                                logic [31:0] py, logic [31:0] ofs);
            bit             sat;
            bit             dummy;
            int             cols;
            int             rows;
            longint         fc, fr, col, row, t, u, y0, y1, h;
            int             base;
            height_result_t r;
            if (fn == FUNC_WRITE) begin
                grid[vidx]    = int'(vh);
                written[vidx] = 1'b1;
                return;
            end
            sat   = 1'b0;
            dummy = 1'b0;
            cols  = clamp_size(cols_cfg);
            rows  = clamp_size(rows_cfg);
            fc    = scale_mul(longint'(signed'(px)) - org_x, inv_sp, longint'(1) <<< 62, dummy);
            fr    = scale_mul(longint'(signed'(pz)) - org_z, inv_sp, longint'(1) <<< 62, dummy);
            col   = cell_of(fc, cols);
            row   = cell_of(fr, rows);
            t     = fc - (col <<< 16);
            u     = fr - (row <<< 16);
            base  = int'(row) * cols + int'(col);
            y0    = lerp(grid[base], grid[base + 1], t, sat);
            y1    = lerp(grid[base + cols], grid[base + cols + 1], t, sat);
            h     = y0 + scale_mul(y1 - y0, u, longint'(1) <<< 62, sat)
                    + longint'(signed'(ofs));
            if (h > 64'sd2147483647) begin sat = 1'b1; h = 64'sd2147483647; end
            if (h < -64'sd2147483648) begin sat = 1'b1; h = -64'sd2147483648; end
            r.surface_height = h[31:0];
            r.below_surface  = longint'(signed'(py)) <= h;
            r.saturated      = sat;
            pending.push_back(r);
        endfunction

        // Called for every done beat
        function void check_result(logic [31:0] sh, logic bs, logic st);
            height_result_t e;
            if (pending.size() == 0) begin
                $error("unexpected result beat: surface_height %0h", sh);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (sh !== e.surface_height) begin
                $error("surface_height: expected %0h, actual %0h", e.surface_height, sh);
                errors++;
            end
            if (bs !== e.below_surface) begin
                $error("below_surface: expected %0b, actual %0b", e.below_surface, bs);
                errors++;
            end
            if (st !== e.saturated) begin
                $error("saturated: expected %0b, actual %0b", e.saturated, st);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 func = FUNC_WRITE;
    logic [15:0]          vertex_index = '0;
    logic signed [31:0]   vertex_height = '0;
    logic signed [31:0]   pos_x = '0;
    logic signed [31:0]   pos_z = '0;
    logic signed [31:0]   pos_y = '0;
    logic signed [31:0]   height_offset = '0;
    logic                 done;
    logic signed [31:0]   surface_height;
    logic                 below_surface;
    logic                 saturated;

    height_scoreboard sb = new();

    heightmap_bilinear_sampler_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .vertex_index   (vertex_index),
        .vertex_height  (vertex_height),
        .pos_x          (pos_x),
        .pos_z          (pos_z),
        .pos_y          (pos_y),
        .height_offset  (height_offset),
        .done           (done),
        .surface_height (surface_height),
        .below_surface  (below_surface),
        .saturated      (saturated)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Monitor: accepted command beats feed the predictor, done beats are checked.
    // Sampled at the rising edge, before the design's own updates land.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_beat(func, vertex_index, vertex_height, pos_x, pos_z, pos_y,
                         height_offset);
        if (rst_n && done)
            sb.check_result(surface_height, below_surface, saturated);
    end

    // ------------------------------------------------------------------
    // Driving tasks: everything changes on the falling edge.
    // ------------------------------------------------------------------
    int gap_max;   // 0 gives back-to-back beats

    // One command beat; start stays high afterward so a zero gap keeps it up.
    task automatic send_beat(logic fn, logic [15:0] vidx, logic [31:0] vh,
                             logic [31:0] px, logic [31:0] pz,
                             logic [31:0] py, logic [31:0] ofs);
        int gap;
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        func          = fn;
        vertex_index  = vidx;
        vertex_height = vh;
        pos_x         = px;
        pos_z         = pz;
        pos_y         = py;
        height_offset = ofs;
        start         = 1'b1;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic write_vertex(logic [15:0] vidx, logic [31:0] vh);
        send_beat(FUNC_WRITE, vidx, vh, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Any corner of the query cell not yet written gets a height first
    task automatic fill_corners(logic [31:0] px, logic [31:0] pz);
        int base;
        int cols;
        int idx;
        base = sb.query_base(px, pz, cols);
        for (int c = 0; c < 4; c++) begin
            idx = base + ((c >= 2) ? cols : 0) + (c % 2);
            if (!sb.written[idx])
                write_vertex(16'(idx), rand_height(1 << 20));
        end
    endtask

    task automatic query(logic [31:0] px, logic [31:0] pz, logic [31:0] py,
                         logic [31:0] ofs);
        fill_corners(px, pz);
        send_beat(FUNC_QUERY, 16'($urandom), $urandom, px, pz, py, ofs);
    endtask

    // Drain the pipeline before touching registers
    task automatic wait_idle();
        start = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (LAT_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Heights: mostly moderate, sometimes anything at all
    function automatic logic [31:0] rand_height(int spread);
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return $urandom_range(0, 2 * spread) - spread;
    endfunction

    // World coordinate that lands near the grid along one axis
    function automatic logic [31:0] near_grid(longint org, int size);
        longint g;
        if (sb.inv_sp == 0)
            return $urandom;
        g = longint'($urandom_range(0, (size + 2) * 65536)) - 65536;
        return 32'(org + (g * 65536) / sb.inv_sp);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int          n;
        int          cols, rows;
        int          spread;
        logic [31:0] px, pz, py, ofs;

        sb.reset_regs();
        gap_max = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extreme heights at both ends of the store, extreme inputs
        write_vertex(16'h0000, 32'h7FFF_FFFF);
        write_vertex(16'h0001, 32'h8000_0000);
        write_vertex(16'h0100, 32'h7FFF_FFFF);
        write_vertex(16'h0101, 32'h8000_0000);
        write_vertex(16'hFFFF, 32'h8000_0000);
        query(32'h0000_8000, 32'h0000_8000, 32'h0, 32'h0);
        query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        query(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
        query(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
        query(32'h00FF_0000, 32'h00FF_0000, 32'h0, 32'h0);
        query(32'h00FE_FFFF, 32'h00FE_FFFF, 32'h8000_0000, 32'h0);
        query(32'hFFFF_0000, 32'h0001_0000, 32'h0, 32'h0);
        write_vertex(16'h0000, 32'h0);
        query(32'h0, 32'h0, 32'h0, 32'h0);   // pos_y exactly on the surface

        // Phases of register settings; extremes in the early ones
        for (int ph = 0; ph < 9; ph++) begin
            wait_idle();
            case (ph)
                0: begin   // smallest grid, bit 31 of inv_spacing data ignored
                    write_reg(REG_ORIGIN_X, 32'h8000_0000);
                    write_reg(REG_ORIGIN_Z, 32'h7FFF_FFFF);
                    write_reg(REG_INV_SPACING, 32'h8000_0001);
                    write_reg(REG_COLS_IN_USE, 32'd2);
                    write_reg(REG_ROWS_IN_USE, 32'd2);
                end
                1: begin   // sizes out of range clamp; zero reciprocal
                    write_reg(REG_ORIGIN_X, 32'h0);
                    write_reg(REG_ORIGIN_Z, 32'h0);
                    write_reg(REG_INV_SPACING, 32'h0);
                    write_reg(REG_COLS_IN_USE, 32'h1FF);
                    write_reg(REG_ROWS_IN_USE, 32'h0);
                end
                2: begin   // largest reciprocal
                    write_reg(REG_INV_SPACING, 32'h7FFF_FFFF);
                    write_reg(REG_COLS_IN_USE, 32'hFFFF_FE01);
                    write_reg(REG_ROWS_IN_USE, 32'd256);
                end
                3: begin
                    write_reg(REG_ORIGIN_X, 32'h7FFF_FFFF);
                    write_reg(REG_ORIGIN_Z, 32'h8000_0000);
                    write_reg(REG_INV_SPACING, 32'h0000_0001);
                    write_reg(REG_COLS_IN_USE, 32'd257);
                    write_reg(REG_ROWS_IN_USE, 32'd1);
                end
                default: begin
                    write_reg(REG_ORIGIN_X, $urandom_range(0, 1 << 24) - (1 << 23));
                    write_reg(REG_ORIGIN_Z, $urandom_range(0, 1 << 24) - (1 << 23));
                    write_reg(REG_INV_SPACING, ($urandom_range(0, 3) == 0) ?
                              $urandom : $urandom_range(1 << 12, 1 << 20));
                    write_reg(REG_COLS_IN_USE, $urandom_range(0, 3) == 0 ?
                              $urandom : $urandom_range(2, 256));
                    write_reg(REG_ROWS_IN_USE, $urandom_range(0, 3) == 0 ?
                              $urandom : $urandom_range(2, 256));
                end
            endcase

            // Back-to-back bursts in every third phase, random gaps in the rest
            gap_max = (ph % 3 == 1) ? 0 : 15;
            spread  = (ph % 2 == 0) ? (1 << 20) : (1 << 30);
            cols    = sb.clamp_size(sb.cols_cfg);
            rows    = sb.clamp_size(sb.rows_cfg);
            n       = 45;
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 9) < 3) begin
                    write_vertex(16'($urandom), rand_height(spread));
                end else begin
                    if ($urandom_range(0, 9) < 7) begin
                        px = near_grid(sb.org_x, cols);
                        pz = near_grid(sb.org_z, rows);
                    end else begin
                        px = $urandom;
                        pz = $urandom;
                    end
                    py  = ($urandom_range(0, 4) == 0) ? $urandom : rand_height(spread);
                    ofs = ($urandom_range(0, 4) == 0) ? $urandom :
                          $urandom_range(0, 1 << 18) - (1 << 17);
                    query(px, pz, py, ofs);
                end
            end
        end

        // Drain and finish
        start = 1'b0;
        for (int w = 0; w < 1000 && sb.pending.size() != 0; w++)
            @(negedge clk);
        repeat (LAT_WAIT) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_top passed");
        end else begin
            if (sb.pending.size() != 0)
                $error("%0d query results never arrived", sb.pending.size());
            $display("tb_top failed");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("tb_top failed");
        $finish;
    end

endmodule
